/* rtl/core/fct_pkg.sv */
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants for the fault code table
// Table depth, field widths, operation codes, the broadcast operation bundle
// and the rank token that walks down the row of slot cells.
// ----------------------------------------------------------------------------
package fct_pkg;

	// number of slots in the table (1 to 31, as the active count is ACT_W bits wide)
	localparam int TABLE_DEPTH = 16;

	// fixed field widths
	localparam int MODE_W = 2;
	localparam int CODE_W = 16;
	localparam int RANK_W = 4;
	localparam int ACT_W  = 5;

	// slot count and running active count both go up to TABLE_DEPTH
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	// width used to compare a running count with the query rank
	localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_SET = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALL = 2'd2;

	// operation broadcast to every cell
	typedef struct packed {
		logic              upd;
		logic [MODE_W-1:0] mode;
		logic [CODE_W-1:0] code;
		logic [RANK_W-1:0] rank;
	} op_t;

	// rank token handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic [CNT_W-1:0]  seen;
		logic              hit;
		logic [CODE_W-1:0] code;
	} tok_t;

endpackage

/* rtl/core/fct_cell.sv */
// ----------------------------------------------------------------------------
// fct_cell: one slot of the fault code table
// Holds a code and an active mark, applies set, clear and append locally and
// advances the rank token by one slot per cycle.
// ----------------------------------------------------------------------------
module fct_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  fct_pkg::op_t  op,
	input  logic          in_use,
	input  logic          append_en,
	output logic          match,
	input  fct_pkg::tok_t tok_in,
	output fct_pkg::tok_t tok_out
);
	import fct_pkg::*;

	logic [CODE_W-1:0] code_q;
	logic              active_q;
	tok_t              tok_q;
	tok_t              tok_nxt;

	// slot in use holding the requested code
	assign match = in_use && (code_q == op.code);

	// slot contents: append, or set / clear of a matching slot
	always_ff @(posedge clk) begin
		priority if (append_en) begin
			code_q   <= op.code;
			active_q <= 1'b1;
		end else if (op.upd && match && (op.mode == MODE_SET)) begin
			active_q <= 1'b1;
		end else if (op.upd && match && (op.mode == MODE_CLR)) begin
			active_q <= 1'b0;
		end else begin
			active_q <= active_q;
		end
	end

	// rank token update for this slot
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.vld && in_use && active_q) begin
			if (!tok_in.hit && (CMP_W'(tok_in.seen) == CMP_W'(op.rank))) begin
				tok_nxt.hit  = 1'b1;
				tok_nxt.code = code_q;
			end
			tok_nxt.seen = tok_in.seen + 1'b1;
		end
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/core/fault_code_table.sv */
// ----------------------------------------------------------------------------
// fault_code_table: diagnostic fault code table
// Row of slot cells with a small controller for slot count and handshakes.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. After an input beat is taken the table is
// updated in the next cycle, then a rank token walks the row of slot cells,
// one cell per cycle, counting active slots and picking the code at the
// requested rank; the result is registered at the end of the row. The next
// input beat is taken only once the result has been taken, so one item is
// finished before the next is accepted. in_stall stays high while an item
// is in progress.
module fault_code_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [fct_pkg::MODE_W-1:0] mode,
	input  logic [fct_pkg::CODE_W-1:0] fault_code,
	input  logic [fct_pkg::RANK_W-1:0] query_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [fct_pkg::ACT_W-1:0]  active_count,
	output logic [fct_pkg::CODE_W-1:0] query_code,
	output logic                       query_hit,
	output logic                       set_dropped
);
	import fct_pkg::*;

	logic                   busy_q;
	logic                   upd_q;
	logic [MODE_W-1:0]      mode_q;
	logic [CODE_W-1:0]      code_q;
	logic [RANK_W-1:0]      rank_q;
	logic [CNT_W-1:0]       used_q;
	logic                   dropped_q;
	tok_t                   tok0_q;
	logic                   out_valid_q;
	logic [ACT_W-1:0]       act_q;
	logic [CODE_W-1:0]      qcode_q;
	logic                   qhit_q;
	logic                   drop_out_q;

	op_t                    op;
	tok_t                   tok [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] in_use;
	logic [TABLE_DEPTH-1:0] tail;
	logic [TABLE_DEPTH-1:0] match;
	logic [TABLE_DEPTH-1:0] append_en;
	logic [TABLE_DEPTH:0]   tok_vld;
	logic                   accept;
	logic                   take;
	logic                   found;
	logic                   full;
	logic                   do_append;

	assign accept = in_valid && !in_stall;
	assign take   = out_valid_q && !out_stall;
	assign in_stall = busy_q;

	// operation bundle seen by every cell
	assign op.upd  = upd_q;
	assign op.mode = mode_q;
	assign op.code = code_q;
	assign op.rank = rank_q;

	assign found     = |match;
	assign full      = (used_q == CNT_W'(TABLE_DEPTH));
	assign do_append = upd_q && (mode_q == MODE_SET) && !found && !full;

	// row of slot cells
	assign tok[0]     = tok0_q;
	assign tok_vld[0] = tok0_q.vld;
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign in_use[i]    = (CNT_W'(i) < used_q);
		assign tail[i]      = (CNT_W'(i) == used_q);
		assign append_en[i] = do_append && tail[i];
		assign tok_vld[i+1] = tok[i+1].vld;

		fct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.in_use    (in_use[i]),
			.append_en (append_en[i]),
			.match     (match[i]),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

	// capture the input beat
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			code_q <= fault_code;
			rank_q <= query_index;
		end
	end

	// drop flag for the update in progress
	always_ff @(posedge clk) begin
		if (upd_q) begin
			dropped_q <= (mode_q == MODE_SET) && !found && full;
		end
	end

	// sequencing, slot count and token launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			upd_q   <= 1'b0;
			used_q  <= '0;
			tok0_q  <= '0;
		end else begin
			upd_q      <= accept;
			tok0_q.vld <= upd_q;
			tok0_q.seen <= '0;
			tok0_q.hit  <= 1'b0;
			tok0_q.code <= '0;
			priority if (accept) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= busy_q;
			end
			priority if (upd_q && (mode_q == MODE_ALL)) begin
				used_q <= '0;
			end else if (do_append) begin
				used_q <= used_q + 1'b1;
			end else begin
				used_q <= used_q;
			end
		end
	end

	// output register at the end of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (tok[TABLE_DEPTH].vld) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (tok[TABLE_DEPTH].vld) begin
			act_q      <= ACT_W'(tok[TABLE_DEPTH].seen);
			qcode_q    <= tok[TABLE_DEPTH].code;
			qhit_q     <= tok[TABLE_DEPTH].hit;
			drop_out_q <= dropped_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign active_count = act_q;
	assign query_code   = qcode_q;
	assign query_hit    = qhit_q;
	assign set_dropped  = drop_out_q;

`ifndef SYNTH
	// slot count never passes the table depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("slot count beyond table depth");

	// at most one rank token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one rank token in flight");

	// a result is only held while its item is in progress
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> busy_q)
		else $error("result without an item in progress");

	// an accepted beat starts the table update in the next cycle
	a_upd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (upd_q && busy_q))
		else $error("update did not follow an accepted beat");
`endif

endmodule

/* bench/fault_code_table_check.sv */
// ----------------------------------------------------------------------------
// fault_code_table_check: result checker for the fault code table
// Watches both channels. Each input beat updates a private copy of the table
// and queues the report that the block must return. Each output beat is
// compared field by field with the oldest queued report.
// ----------------------------------------------------------------------------
module fault_code_table_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [fct_pkg::MODE_W-1:0] mode,
	input  logic [fct_pkg::CODE_W-1:0] fault_code,
	input  logic [fct_pkg::RANK_W-1:0] query_index,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [fct_pkg::ACT_W-1:0]  active_count,
	input  logic [fct_pkg::CODE_W-1:0] query_code,
	input  logic                       query_hit,
	input  logic                       set_dropped,
	output int                         mismatch_cnt,
	output int                         reports_owed
);

	import fct_pkg::*;

	// one report beat
	typedef struct packed {
		logic [ACT_W-1:0]  active_count;
		logic [CODE_W-1:0] query_code;
		logic              query_hit;
		logic              set_dropped;
	} report_t;

	// private copy of the table
	logic [CODE_W-1:0] tbl_code [TABLE_DEPTH];
	bit                tbl_act  [TABLE_DEPTH];
	int                slots_in_use;

	report_t report_q [$];
	int      err_total;

	// apply one operation to the table copy and work out its report
	task automatic apply_fault_op(input logic [MODE_W-1:0] op, input logic [CODE_W-1:0] code,
			input logic [RANK_W-1:0] rank, output report_t rep);
		int i;
		int seen;
		bit found;
		rep   = '0;
		found = 1'b0;
		seen  = 0;
		case (op)
			MODE_SET: begin
				for (i = 0; i < slots_in_use; i++)
					if (!found && tbl_code[i] == code) begin
						tbl_act[i] = 1'b1;
						found      = 1'b1;
					end
				// new code goes to the next free slot, or is refused when full
				if (!found) begin
					if (slots_in_use >= TABLE_DEPTH)
						rep.set_dropped = 1'b1;
					else begin
						tbl_code[slots_in_use] = code;
						tbl_act[slots_in_use]  = 1'b1;
						slots_in_use++;
					end
				end
			end
			MODE_CLR: begin
				for (i = 0; i < slots_in_use; i++)
					if (tbl_code[i] == code)
						tbl_act[i] = 1'b0;
			end
			MODE_ALL: begin
				slots_in_use = 0;
			end
			default: ;
		endcase
		// rank walk over active slots in insertion order
		for (i = 0; i < slots_in_use; i++) begin
			if (tbl_act[i]) begin
				if (!rep.query_hit && seen == int'(rank)) begin
					rep.query_hit  = 1'b1;
					rep.query_code = tbl_code[i];
				end
				seen++;
			end
		end
		rep.active_count = seen[ACT_W-1:0];
	endtask

	// report one field that differs
	task automatic check_field(input string name, input logic [CODE_W-1:0] want,
			input logic [CODE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_total++;
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		report_t got;
		if (!arst_n) begin
			slots_in_use = 0;
			err_total    = 0;
			report_q.delete();
			mismatch_cnt <= 0;
			reports_owed <= 0;
		end else begin
			// input beat: predict its report
			if (in_valid && !in_stall) begin
				apply_fault_op(mode, fault_code, query_index, want);
				report_q.push_back(want);
			end
			// output beat: compare with the oldest report
			if (out_valid && !out_stall) begin
				got.active_count = active_count;
				got.query_code   = query_code;
				got.query_hit    = query_hit;
				got.set_dropped  = set_dropped;
				if (report_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time, got);
					err_total++;
				end else begin
					want = report_q.pop_front();
					check_field("active_count", CODE_W'(want.active_count),
						CODE_W'(got.active_count));
					check_field("query_code", want.query_code, got.query_code);
					check_field("query_hit", CODE_W'(want.query_hit), CODE_W'(got.query_hit));
					check_field("set_dropped", CODE_W'(want.set_dropped),
						CODE_W'(got.set_dropped));
				end
			end
			reports_owed <= report_q.size();
			mismatch_cnt <= err_total;
		end
	end

endmodule

/* bench/fault_code_table_test.sv */
// ----------------------------------------------------------------------------
// fault_code_table_test: testbench top for the fault code table
// Drives directed and random set, clear, clear-all and unused-mode beats with
// random gaps and result stalls, including two long result hold-offs and a full
// drain, and gives the verdict from the checker's mismatch and owed-report counts.
// ----------------------------------------------------------------------------
module fault_code_table_test;

	import fct_pkg::*;

	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
	localparam int RAND_ITEMS = 525;
	localparam int POOL_SIZE  = 20;
	localparam int LONG_HOLD  = 150;
	localparam int CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [MODE_W-1:0] mode;
	logic [CODE_W-1:0] fault_code;
	logic [RANK_W-1:0] query_index;
	logic              out_valid;
	logic              out_stall;
	logic [ACT_W-1:0]  active_count;
	logic [CODE_W-1:0] query_code;
	logic              query_hit;
	logic              set_dropped;
	int                mismatch_cnt;
	int                reports_owed;
	int                tx_calm;
	int                cycle_cnt;
	logic [CODE_W-1:0] code_pool [POOL_SIZE];

	fault_code_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.fault_code   (fault_code),
		.query_index  (query_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.active_count (active_count),
		.query_code   (query_code),
		.query_hit    (query_hit),
		.set_dropped  (set_dropped)
	);

	fault_code_table_check check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.fault_code   (fault_code),
		.query_index  (query_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.active_count (active_count),
		.query_code   (query_code),
		.query_hit    (query_hit),
		.set_dropped  (set_dropped),
		.mismatch_cnt (mismatch_cnt),
		.reports_owed (reports_owed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	// result side: random stalls per beat, calm stretches, two long hold-offs
	initial begin : result_sink
		int rx_gap;
		int rx_calm;
		int rx_beats;
		int hold_left;
		rx_gap    = 0;
		rx_calm   = 0;
		rx_beats  = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0)
				hold_left--;
			if (out_valid && !out_stall) begin
				rx_beats++;
				if (rx_beats == 60 || rx_beats == 400)
					hold_left = LONG_HOLD;
				if (rx_calm > 0) begin
					rx_calm--;
					rx_gap = 0;
				end else begin
					if ($urandom_range(0, 31) == 0)
						rx_calm = 25;
					rx_gap = $urandom_range(0, 3);
				end
			end else if (out_valid && rx_gap > 0)
				rx_gap--;
			out_stall <= (rx_gap > 0) || (hold_left > 0);
		end
	end

	// offer one beat, hold it until taken, then idle for a random gap
	task automatic offer_item(input logic [MODE_W-1:0] m, input logic [CODE_W-1:0] c,
			input logic [RANK_W-1:0] r);
		int gap;
		in_valid    <= 1'b1;
		mode        <= m;
		fault_code  <= c;
		query_index <= r;
		do @(posedge clk); while (in_stall);
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 31) == 0)
				tx_calm = 25;
			gap = $urandom_range(0, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering until every queued report has come back
	task automatic await_all_reports();
		in_valid <= 1'b0;
		do @(posedge clk); while (reports_owed != 0);
	endtask

	// new random code pool
	task automatic refresh_pool();
		int i;
		for (i = 0; i < POOL_SIZE; i++)
			code_pool[i] = $urandom;
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int n;
		int i;
		int pick;
		logic [MODE_W-1:0] m;
		logic [CODE_W-1:0] c;
		tx_calm     = 0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		mode        <= MODE_NOP;
		fault_code  <= '0;
		query_index <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: unused mode, clear and clear-all
		offer_item(MODE_NOP, 16'hFFFF, 4'd15);
		offer_item(MODE_CLR, 16'h0000, 4'd0);
		offer_item(MODE_ALL, 16'h5A5A, 4'd0);
		// extreme codes, repeated set, clear then set again keeps the slot order
		offer_item(MODE_SET, 16'h0000, 4'd0);
		offer_item(MODE_SET, 16'hFFFF, 4'd1);
		offer_item(MODE_SET, 16'hFFFF, 4'd1);
		offer_item(MODE_CLR, 16'h0000, 4'd0);
		offer_item(MODE_SET, 16'h0000, 4'd0);
		// fill the table
		for (i = 0; i < TABLE_DEPTH - 2; i++)
			offer_item(MODE_SET, CODE_W'(16'h1000 + i), RANK_W'(i + 2));
		// full table: new code dropped, inactive slot still counts as used
		offer_item(MODE_SET, 16'hABCD, 4'd15);
		offer_item(MODE_CLR, 16'h1000, 4'd15);
		offer_item(MODE_SET, 16'h8001, 4'd14);
		offer_item(MODE_SET, 16'h1000, 4'd15);
		offer_item(MODE_ALL, 16'hFFFF, 4'd15);
		await_all_reports();

		// random part: pool codes so sets hit, clears match and the table fills
		refresh_pool();
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2)
				await_all_reports();
			if ($urandom_range(0, 59) == 0)
				refresh_pool();
			if ($urandom_range(0, 9) == 0)
				c = $urandom;
			else
				c = code_pool[$urandom_range(0, POOL_SIZE - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 66)
				m = MODE_SET;
			else if (pick < 94)
				m = MODE_CLR;
			else if (pick < 96)
				m = MODE_ALL;
			else
				m = MODE_NOP;
			offer_item(m, c, RANK_W'($urandom_range(0, 15)));
		end

		// drain, then allow for a late stray beat
		await_all_reports();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatch_cnt == 0 && reports_owed == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/fct_pkg.sv
rtl/core/fct_cell.sv
rtl/core/fault_code_table.sv
bench/fault_code_table_check.sv
bench/fault_code_table_test.sv
